/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the allocator core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* design/cca_pkg.sv */
// ---------------------------------------------------------------------------
// cca_pkg
// Constants, codes and types for the chained cell allocator.
// ---------------------------------------------------------------------------
`default_nettype none
package cca_pkg;
  localparam int CCA_DEPTH     = 64;
  localparam int CCA_TAG_BITS  = 16;
  localparam int CCA_DATA_BITS = 32;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_PUT   = 2'd2;
  localparam logic [1:0] KIND_GET   = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NO_ROOM   = 3'd2;
  localparam logic [2:0] STAT_ADDR_FREE = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic link_we;
    logic tag_we;
    logic data_we;
    logic data_clr;
  } cca_wr_t;
endpackage
`default_nettype wire

/* design/cca_cell_store.sv */
// ---------------------------------------------------------------------------
// cca_cell_store
// Link, tag and data memories with one registered read port; unwritten
// links read as the reset chain and unwritten data as the default word.
// ---------------------------------------------------------------------------
`default_nettype none
module cca_cell_store #(
  parameter int DEPTH     = 64,
  parameter int TAG_BITS  = 16,
  parameter int DATA_BITS = 32,
  parameter int AW        = 6,
  parameter int LW        = 7
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [AW-1:0]         rd_addr,
  input  wire cca_pkg::cca_wr_t wr,
  input  wire [AW-1:0]         link_waddr,
  input  wire [LW-1:0]         link_wdata,
  input  wire [AW-1:0]         tag_waddr,
  input  wire [TAG_BITS-1:0]   tag_wdata,
  input  wire [AW-1:0]         data_waddr,
  input  wire [DATA_BITS-1:0]  data_wdata,
  input  wire [DATA_BITS-1:0]  default_val,
  output logic [LW-1:0]        link_q,
  output logic [TAG_BITS-1:0]  tag_q,
  output logic [DATA_BITS-1:0] data_q
);
  import cca_pkg::*;

  logic [LW-1:0]        link_mem [DEPTH];
  logic [TAG_BITS-1:0]  tag_mem  [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];
  logic [DEPTH-1:0]     link_vld;
  logic [DEPTH-1:0]     data_vld;
  logic [LW-1:0]        link_raw;
  logic [DATA_BITS-1:0] data_raw;
  logic                 link_v;
  logic                 data_v;
  logic [AW-1:0]        addr_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      data_vld <= '0;
    end else begin
      if (wr.link_we) link_vld[link_waddr] <= 1'b1;
      if (wr.data_clr) data_vld <= '0;
      else if (wr.data_we) data_vld[data_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.link_we) link_mem[link_waddr] <= link_wdata;
    if (wr.tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (wr.data_we) data_mem[data_waddr] <= data_wdata;
  end

  always_ff @(posedge clk) begin
    link_raw <= link_mem[rd_addr];
    tag_q    <= tag_mem[rd_addr];
    data_raw <= data_mem[rd_addr];
    link_v   <= link_vld[rd_addr];
    data_v   <= data_vld[rd_addr];
    addr_q   <= rd_addr;
  end

  always_comb begin
    if (link_v) link_q = link_raw;
    else if (addr_q == AW'(DEPTH - 1)) link_q = LW'(DEPTH);
    else link_q = LW'(addr_q) + LW'(1);
    data_q = data_v ? data_raw : default_val;
  end
endmodule
`default_nettype wire

/* design/chained_cell_allocator_core.sv */
// Steps: free and put check the free list, then walk the chain; get walks
// the chain; every request then recounts the free list, each cell read
// through the registered memory read port.
// One request at a time; busy covers done (none on a non-last allocate).
// Result shows for one cycle on done; the receiver cannot stall.
// Synchronous reset: empty runs, full free list, data words read as default.
`default_nettype none
module chained_cell_allocator_core #(
  parameter int DEPTH     = cca_pkg::CCA_DEPTH,
  parameter int TAG_BITS  = cca_pkg::CCA_TAG_BITS,
  parameter int DATA_BITS = cca_pkg::CCA_DATA_BITS,
  parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int LW        = $clog2(DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire [1:0]            kind,
  input  wire [AW-1:0]         addr,
  input  wire [TAG_BITS-1:0]   tag,
  input  wire [DATA_BITS-1:0]  value,
  input  wire [LW-1:0]         count,
  input  wire                  last,
  output logic                 done,
  output logic [2:0]           status,
  output logic [AW-1:0]        head_addr,
  output logic [DATA_BITS-1:0] data_out,
  output logic [LW-1:0]        free_cells,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [DATA_BITS-1:0]  cfg_data
);
  import cca_pkg::*;
  `include "assert_macros.svh"

  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_EV   = 3'd3;
  localparam logic [2:0] ST_ALOC = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam logic [2:0] PH_TAKE   = 3'd0;
  localparam logic [2:0] PH_ONFREE = 3'd1;
  localparam logic [2:0] PH_CHAIN  = 3'd2;
  localparam logic [2:0] PH_SCAN   = 3'd3;
  localparam logic [2:0] PH_COUNT  = 3'd4;

  localparam logic [1:0] RUN_IDLE   = 2'd0;
  localparam logic [1:0] RUN_ACTIVE = 2'd1;
  localparam logic [1:0] RUN_FULL   = 2'd2;
  localparam logic [1:0] RUN_NOROOM = 2'd3;

  logic [2:0]           state;
  logic [2:0]           phase;
  logic [LW-1:0]        ptr;
  logic [LW-1:0]        n;
  logic [1:0]           k;
  logic [AW-1:0]        a;
  logic [TAG_BITS-1:0]  t;
  logic [DATA_BITS-1:0] v;
  logic                 lst;
  logic [LW-1:0]        free_head;
  logic [LW-1:0]        free_count;
  logic [LW-1:0]        cursor;
  logic [AW-1:0]        run_head;
  logic [AW-1:0]        run_tail;
  logic [1:0]           run_state;
  logic [2:0]           stat;
  logic [AW-1:0]        head;
  logic [DATA_BITS-1:0] dout;
  logic                 found;
  logic [DATA_BITS-1:0] default_value;

  logic                 accept;
  logic                 cfg_wr;
  logic [LW-1:0]        cnt_in;
  logic [1:0]           rs_new;
  logic [LW-1:0]        cursor_eff;
  logic                 take;
  logic                 chain_more;
  logic                 walk_ok;
  logic                 step_more;
  logic                 match;
  logic [LW-1:0]        n_inc;

  cca_wr_t              wr;
  logic [AW-1:0]        link_waddr;
  logic [LW-1:0]        link_wdata;
  logic [LW-1:0]        link_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [DATA_BITS-1:0] data_q;

  assign accept    = start && (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_OUT);
  assign status    = stat;
  assign head_addr = head;
  assign data_out  = dout;
  assign free_cells = free_count;

  always_comb begin
    cnt_in = (count == '0) ? LW'(1) : count;
    if (run_state != RUN_IDLE) rs_new = run_state;
    else if (free_count == '0) rs_new = RUN_FULL;
    else if (cnt_in > free_count) rs_new = RUN_NOROOM;
    else rs_new = RUN_ACTIVE;
    cursor_eff = (run_state == RUN_IDLE) ? '0 : cursor;
    take = (rs_new == RUN_ACTIVE) && (cursor_eff < cnt_in) && (free_head < NIL);
    n_inc = n + LW'(1);
    walk_ok = (ptr < NIL) && (n < NIL);
    step_more = (link_q < NIL) && (n_inc < NIL);
    chain_more = (link_q < NIL) && (n < NIL);
    match = (tag_q == t);
  end

  always_comb begin
    wr = '0;
    link_waddr = run_tail;
    link_wdata = NIL;
    wr.data_clr = cfg_wr;
    wr.tag_we = accept && (kind == KIND_ALLOC) && take;
    if (accept && (kind != KIND_ALLOC) && (run_state == RUN_ACTIVE) && (cursor != '0))
      wr.link_we = 1'b1;
    if ((state == ST_ALOC) && lst && (run_state == RUN_ACTIVE) && (cursor != '0))
      wr.link_we = 1'b1;
    if ((state == ST_EV) && (phase == PH_CHAIN) && !chain_more) begin
      wr.link_we = 1'b1;
      link_waddr = ptr[AW-1:0];
      link_wdata = free_head;
    end
    wr.data_we = (state == ST_EV) && (phase == PH_SCAN) && (k == KIND_PUT) && match;
  end

  cca_cell_store #(
    .DEPTH(DEPTH), .TAG_BITS(TAG_BITS), .DATA_BITS(DATA_BITS), .AW(AW), .LW(LW)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .rd_addr(ptr[AW-1:0]),
    .wr(wr),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .tag_waddr(free_head[AW-1:0]),
    .tag_wdata(tag),
    .data_waddr(ptr[AW-1:0]),
    .data_wdata(v),
    .default_val(default_value),
    .link_q(link_q),
    .tag_q(tag_q),
    .data_q(data_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_COUNT;
      free_head     <= '0;
      free_count    <= NIL;
      cursor        <= '0;
      run_head      <= '0;
      run_tail      <= '0;
      run_state     <= RUN_IDLE;
      default_value <= '0;
      ptr           <= '0;
      n             <= '0;
      found         <= 1'b0;
    end else begin
      if (cfg_wr) default_value <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            k     <= kind;
            a     <= addr;
            t     <= tag;
            v     <= value;
            lst   <= last;
            stat  <= STAT_OK;
            head  <= '0;
            dout  <= '0;
            found <= 1'b0;
            n     <= '0;
            if (kind == KIND_ALLOC) begin
              run_state <= rs_new;
              if (run_state == RUN_IDLE) begin
                run_head <= free_head[AW-1:0];
                cursor   <= '0;
              end
              if (take) begin
                phase <= PH_TAKE;
                ptr   <= free_head;
                state <= ST_RD;
              end else begin
                state <= ST_ALOC;
              end
            end else begin
              run_state <= RUN_IDLE;
              state     <= ST_CHK;
              if (kind == KIND_GET) begin
                phase <= PH_SCAN;
                ptr   <= LW'(addr);
              end else if (LW'(addr) >= NIL) begin
                stat  <= STAT_ADDR_FREE;
                phase <= PH_COUNT;
                ptr   <= free_head;
              end else begin
                phase <= PH_ONFREE;
                ptr   <= free_head;
              end
            end
          end
        end
        ST_CHK: begin
          if (walk_ok) begin
            state <= ST_RD;
          end else begin
            case (phase)
              PH_ONFREE: begin
                phase <= (k == KIND_FREE) ? PH_CHAIN : PH_SCAN;
                ptr   <= LW'(a);
                n     <= '0;
                state <= ST_RD;
              end
              PH_SCAN: begin
                if (!found) stat <= STAT_NOT_FOUND;
                phase <= PH_COUNT;
                ptr   <= free_head;
                n     <= '0;
              end
              default: begin
                free_count <= n;
                state <= ((k != KIND_ALLOC) || lst) ? ST_OUT : ST_IDLE;
              end
            endcase
          end
        end
        ST_RD: state <= ST_EV;
        ST_EV: begin
          case (phase)
            PH_TAKE: begin
              free_head <= link_q;
              run_tail  <= ptr[AW-1:0];
              cursor    <= cursor + LW'(1);
              state     <= ST_ALOC;
            end
            PH_ONFREE: begin
              if (ptr[AW-1:0] == a) begin
                stat  <= STAT_ADDR_FREE;
                phase <= PH_COUNT;
                ptr   <= free_head;
                n     <= '0;
                state <= ST_CHK;
              end else begin
                ptr   <= link_q;
                n     <= n_inc;
                state <= step_more ? ST_RD : ST_CHK;
              end
            end
            PH_CHAIN: begin
              if (chain_more) begin
                ptr   <= link_q;
                n     <= n_inc;
                state <= ST_RD;
              end else begin
                free_head <= LW'(a);
                phase     <= PH_COUNT;
                ptr       <= LW'(a);
                n         <= '0;
                state     <= ST_CHK;
              end
            end
            PH_SCAN: begin
              if (match) begin
                found <= 1'b1;
                if (k == KIND_GET) dout <= data_q;
              end
              ptr   <= link_q;
              n     <= n_inc;
              state <= step_more ? ST_RD : ST_CHK;
            end
            default: begin
              ptr   <= link_q;
              n     <= n_inc;
              state <= step_more ? ST_RD : ST_CHK;
            end
          endcase
        end
        ST_ALOC: begin
          if (lst) begin
            if ((run_state == RUN_ACTIVE) && (cursor != '0)) head <= run_head;
            else if (run_state == RUN_NOROOM) stat <= STAT_NO_ROOM;
            else stat <= STAT_FULL;
            run_state <= RUN_IDLE;
            cursor    <= '0;
          end
          phase <= PH_COUNT;
          ptr   <= free_head;
          n     <= '0;
          state <= ST_CHK;
        end
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(ap_free_range, clk, rst, free_count > NIL)
  `ASSERT_PROP(ap_cfg_idle, clk, rst, cfg_valid && cfg_ready |-> !busy)
  `ASSERT_PROP(ap_done_single, clk, rst, done |=> !done && !busy)
  `ASSERT_PROP(ap_start_busy, clk, rst, start && !busy |=> busy)
endmodule
`default_nettype wire
